/* rtl/virtual_timer_bank_unit_assert.svh */
// assertion macros shared by the timer bank rtl
`ifndef VIRTUAL_TIMER_BANK_UNIT_ASSERT_SVH
`define VIRTUAL_TIMER_BANK_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define VTB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("timer bank check failed");

// next-cycle implication, checked outside reset
`define VTB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("timer bank check failed");

`endif

/* rtl/vtb_pkg.sv */
package vtb_pkg;

    localparam int TIMER_SLOTS_DEF = 16;

    localparam int KIND_W    = 2;
    localparam int DUR_W     = 16;
    localparam int TPM_W     = 16;
    localparam int SLOT_ID_W = 4;
    localparam int MASK_W    = 16;
    localparam int COUNT_W   = 32;

    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_START = 2'd1;
    localparam logic [KIND_W-1:0] KIND_STOP  = 2'd2;

    localparam logic [TPM_W-1:0] TPM_RESET = 16'd1;

    // command broadcast to every cell of the chain
    typedef struct packed {
        logic               tick;
        logic               start;
        logic               periodic;
        logic [COUNT_W-1:0] count;
    } t_cmd;

    // per-cell report back to the top level
    typedef struct packed {
        logic claim;
        logic fired;
    } t_cell_flags;

endpackage

/* rtl/vtb_cell.sv */
module vtb_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  vtb_pkg::t_cmd       i_cmd,
    input  logic               i_stop_hit,
    input  logic               i_found_in,
    output logic               o_found_out,
    output vtb_pkg::t_cell_flags o_flags
);
    import vtb_pkg::*;

    logic               r_running;
    logic               r_periodic;
    logic [COUNT_W-1:0] r_remaining;
    logic [COUNT_W-1:0] r_reload;

    logic               n_running;
    logic               n_periodic;
    logic [COUNT_W-1:0] n_remaining;
    logic [COUNT_W-1:0] n_reload;

    logic w_claim;
    logic w_expire;
    logic w_fire;

    // free-slot search ripples from the lowest slot upward
    assign w_claim     = i_cmd.start & ~r_running & ~i_found_in;
    assign o_found_out = i_found_in | ~r_running;

    // remaining count of zero or one
    assign w_expire = (r_remaining[COUNT_W-1:1] == '0);
    assign w_fire   = i_cmd.tick & r_running & w_expire;

    assign o_flags.claim = w_claim;
    assign o_flags.fired = w_fire;

    always_comb begin
        n_running   = r_running;
        n_periodic  = r_periodic;
        n_remaining = r_remaining;
        n_reload    = r_reload;
        priority if (w_claim) begin
            n_running   = 1'b1;
            n_periodic  = i_cmd.periodic;
            n_remaining = i_cmd.count;
            n_reload    = i_cmd.count;
        end else if (i_stop_hit) begin
            n_running = 1'b0;
        end else if (i_cmd.tick && r_running) begin
            if (w_expire) begin
                if (r_periodic) begin
                    n_remaining = r_reload;
                end else begin
                    n_running = 1'b0;
                end
            end else begin
                n_remaining = r_remaining - COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running  <= 1'b0;
            r_periodic <= 1'b0;
        end else begin
            r_running  <= n_running;
            r_periodic <= n_periodic;
        end
        r_remaining <= n_remaining;
        r_reload    <= n_reload;
    end

endmodule

/* rtl/virtual_timer_bank_unit.sv */
// Bank of down-counting timers behind one command port. A transfer happens at
// each clock edge with start high and busy low; busy stays low, so a command
// (tick, start timer, stop timer) may be issued every cycle. Each command gives
// exactly one result after its transfer: the first stage scales the duration
// by ticks_per_ms in a single 16x16 multiplier and registers it, the second
// applies the command to the chain of timer cells and registers the result.
// The result sits on the o_ ports for one cycle with o_done high and must be
// taken then, since the receiver cannot stall the block. A start claims the
// lowest free slot through a ripple along the cells; a full bank answers
// o_status high. A tick decrements every running timer; a timer at one or zero
// fires, then stops (one-shot) or reloads its period (periodic), and o_fired_mask
// reports the firing slots. Write ticks_per_ms only while no command is in flight.
module virtual_timer_bank_unit #(
    parameter int TIMER_SLOTS = vtb_pkg::TIMER_SLOTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [vtb_pkg::KIND_W-1:0]    i_kind,
    input  logic [vtb_pkg::DUR_W-1:0]     i_duration_ms,
    input  logic                          i_periodic,
    input  logic [vtb_pkg::SLOT_ID_W-1:0] i_stop_id,
    input  logic                          i_cfg_we,
    input  logic [vtb_pkg::TPM_W-1:0]     i_cfg_wdata,
    output logic                          o_done,
    output logic                          o_status,
    output logic [vtb_pkg::SLOT_ID_W-1:0] o_assigned_id,
    output logic [vtb_pkg::MASK_W-1:0]    o_fired_mask
);
    import vtb_pkg::*;

`include "virtual_timer_bank_unit_assert.svh"

    // slots that can be named by stop_id or shown in the fired mask
    localparam int NAMED_SLOTS = 1 << SLOT_ID_W;
    localparam int MASK_N      = (TIMER_SLOTS < MASK_W) ? TIMER_SLOTS : MASK_W;

    // configuration
    logic [TPM_W-1:0] r_tpm;

    // stage one: command captured with its scaled count
    logic                 r_s1_valid;
    logic [KIND_W-1:0]    r_s1_kind;
    logic                 r_s1_periodic;
    logic [SLOT_ID_W-1:0] r_s1_stop_id;
    logic [COUNT_W-1:0]   r_s1_count;

    // result registers
    logic                 r_done;
    logic                 r_status;
    logic [SLOT_ID_W-1:0] r_assigned_id;
    logic [MASK_W-1:0]    r_fired_mask;

    logic                 w_accept;
    logic [COUNT_W-1:0]   w_product;
    t_cmd                 w_cmd;
    logic                 w_stop;
    logic [TIMER_SLOTS-1:0] w_stop_hit;
    logic [TIMER_SLOTS:0]   w_found;
    t_cell_flags          w_flags [TIMER_SLOTS];
    logic [TIMER_SLOTS-1:0] w_claim;
    logic [SLOT_ID_W-1:0] w_claim_id;
    logic [MASK_W-1:0]    w_mask;
    logic                 w_full;

    // never stalls, one transfer per cycle
    assign busy     = 1'b0;
    assign w_accept = start & ~busy;

    // 16x16 product always fits the 32 bit count
    assign w_product = COUNT_W'(i_duration_ms) * COUNT_W'(r_tpm);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tpm <= TPM_RESET;
        end else if (i_cfg_we) begin
            r_tpm <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_accept;
        end
        if (w_accept) begin
            r_s1_kind     <= i_kind;
            r_s1_periodic <= i_periodic;
            r_s1_stop_id  <= i_stop_id;
            r_s1_count    <= w_product;
        end
    end

    // decode the staged command for the cells
    assign w_cmd.tick     = r_s1_valid && (r_s1_kind == KIND_TICK);
    assign w_cmd.start    = r_s1_valid && (r_s1_kind == KIND_START);
    assign w_cmd.periodic = r_s1_periodic;
    assign w_cmd.count    = r_s1_count;
    assign w_stop         = r_s1_valid && (r_s1_kind == KIND_STOP);

    // only slots within the id range can be stopped
    always_comb begin
        w_stop_hit = '0;
        for (int i = 0; i < TIMER_SLOTS; i++) begin
            if (i < NAMED_SLOTS) begin
                w_stop_hit[i] = w_stop && (r_s1_stop_id == SLOT_ID_W'(i));
            end
        end
    end

    // chain of timer cells, free-slot flag handed from each to the next
    assign w_found[0] = 1'b0;

    for (genvar g = 0; g < TIMER_SLOTS; g++) begin : g_cell
        vtb_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cmd       (w_cmd),
            .i_stop_hit  (w_stop_hit[g]),
            .i_found_in  (w_found[g]),
            .o_found_out (w_found[g+1]),
            .o_flags     (w_flags[g])
        );
        assign w_claim[g] = w_flags[g].claim;
    end

    // at most one claim, so an or of slot numbers gives its id
    always_comb begin
        w_claim_id = '0;
        for (int i = 0; i < TIMER_SLOTS; i++) begin
            if (w_claim[i]) begin
                w_claim_id = w_claim_id | SLOT_ID_W'(i);
            end
        end
    end

    // wide banks report only the low slots
    always_comb begin
        w_mask = '0;
        for (int i = 0; i < MASK_N; i++) begin
            w_mask[i] = w_flags[i].fired;
        end
    end

    assign w_full = ~w_found[TIMER_SLOTS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_s1_valid;
        end
        r_status      <= w_cmd.start & w_full;
        r_assigned_id <= w_claim_id;
        r_fired_mask  <= w_mask;
    end

    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_assigned_id = r_assigned_id;
    assign o_fired_mask  = r_fired_mask;

    // every staged command gives a result the next cycle
    `VTB_ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, r_s1_valid, o_done)
    // the lowest-free search grants at most one slot
    `VTB_ASSERT_NOW(a_single_claim, i_clk, i_rst_n, 1'b1, $onehot0(w_claim))
    // a refused start carries no slot and no fired bits
    `VTB_ASSERT_NOW(a_full_clean, i_clk, i_rst_n, o_done && o_status,
                    (o_assigned_id == '0) && (o_fired_mask == '0))
    // a claim happens exactly when a start finds room
    `VTB_ASSERT_NOW(a_claim_on_room, i_clk, i_rst_n, w_cmd.start,
                    (w_claim != '0) == !w_full)
    // fired bits appear only in answer to a tick
    `VTB_ASSERT_NEXT(a_fire_on_tick, i_clk, i_rst_n, r_s1_valid && !w_cmd.tick,
                     o_fired_mask == '0)

endmodule
